/* rtl/core/circle_segment_capsule_test_assert.svh */
// Assertion macros shared by the circle/capsule test RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef CIRCLE_SEGMENT_CAPSULE_TEST_ASSERT_SVH
`define CIRCLE_SEGMENT_CAPSULE_TEST_ASSERT_SVH

// Same-cycle implication.
`define CSCT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csct: assertion failed");

// Next-cycle implication.
`define CSCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csct: assertion failed");

`endif

/* rtl/core/csct_pkg.sv */
// Shared types and constants for the circle/capsule intersection test.
// No dependencies.
package csct_pkg;

    localparam int RADIUS_WIDTH = 15;
    localparam int RSUM_WIDTH   = RADIUS_WIDTH + 1;
    localparam int R2_WIDTH     = 2 * RSUM_WIDTH;

    // Where the closest point on the segment lies.
    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_END      = 2'd1,
        REGION_INTERIOR = 2'd2
    } region_t;

endpackage

/* rtl/core/csct_query_if.sv */
// Query channel: valid/ready handshake carrying one circle and one segment.
// Depends on csct_pkg.
interface csct_query_if #(
    parameter int COORD_WIDTH = 16
);
    logic                                 valid;
    logic                                 ready;
    logic signed [COORD_WIDTH-1:0]        circle_x;
    logic signed [COORD_WIDTH-1:0]        circle_y;
    logic signed [COORD_WIDTH-1:0]        seg_ax;
    logic signed [COORD_WIDTH-1:0]        seg_ay;
    logic signed [COORD_WIDTH-1:0]        seg_bx;
    logic signed [COORD_WIDTH-1:0]        seg_by;
    logic [csct_pkg::RADIUS_WIDTH-1:0]    circle_radius;
    logic [csct_pkg::RADIUS_WIDTH-1:0]    capsule_radius;

    modport source (
        output valid, circle_x, circle_y, seg_ax, seg_ay, seg_bx, seg_by,
               circle_radius, capsule_radius,
        input  ready
    );

    modport sink (
        input  valid, circle_x, circle_y, seg_ax, seg_ay, seg_bx, seg_by,
               circle_radius, capsule_radius,
        output ready
    );
endinterface

/* rtl/core/csct_result_if.sv */
// Result channel: valid/ready handshake carrying the hit flag and region.
// No dependencies.
interface csct_result_if;
    logic       valid;
    logic       ready;
    logic       intersecting;
    logic [1:0] closest_region;

    modport source (
        output valid, intersecting, closest_region,
        input  ready
    );

    modport sink (
        input  valid, intersecting, closest_region,
        output ready
    );
endinterface

/* rtl/core/circle_segment_capsule_test.sv */
// Circle versus capsule (or segment) intersection test, seven-stage pipeline.
// Depends on csct_pkg, csct_query_if, csct_result_if and the assert header.
//
// One query beat (circle center and segment A-B in Q8.8, circle and capsule
// radius in UQ7.8) produces exactly one result beat after stages s1 to s7:
// a hit flag (closest distance <= circle_radius + capsule_radius, touching
// counts) and the region of the closest point (clamped to A, clamped to B,
// or inside the segment). The pipeline takes one beat per clock; throughput is one
// result per cycle as long as result.ready is high. Each stage holds its beat
// when the stage after it is full and stalled, so back-pressure fills bubbles
// before query.ready drops, and the output register lets a new query in while
// a finished result waits. The math is exact integer: squared distances are
// compared with (r+q)^2, and an interior closest point is tested as
// cross(AC,AB)^2 <= (r+q)^2 * |AB|^2, so there is no divider and no root. A
// degenerate segment (A equals B) reports region "start" and uses the distance
// to A. The widest multipliers are (COORD_WIDTH+1) x (COORD_WIDTH+1) and
// 32 x (COORD_WIDTH+1); the cross-product square and the radius-times-length
// product are each split into halves over one stage and summed in the next.
//   s1 differences   s2 products      s3 dot/cross sums
//   s4 region, end-point hit, |cross|  s5 split products
//   s6 wide sums     s7 final compare (output register)
module circle_segment_capsule_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    csct_query_if.sink           query,
    csct_result_if.source        result
);

    localparam int DW  = COORD_WIDTH + 1;          // coordinate difference
    localparam int PW  = 2 * DW;                   // signed product
    localparam int SW  = PW + 1;                   // sum of two products
    localparam int MW  = PW;                       // |cross| and |AB|^2 magnitude
    localparam int H   = DW;                       // half of an MW word
    localparam int R2W = csct_pkg::R2_WIDTH;
    localparam int RSW = csct_pkg::RSUM_WIDTH;
    localparam int LW  = 2 * MW;                   // cross^2
    localparam int RHW = R2W + MW;                 // r^2 * len^2
    localparam int CW  = (LW > RHW) ? LW : RHW;
    localparam int BW  = (SW > R2W) ? SW : R2W;

    // ---------------------------------------------------------------- flow
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

    // A stage loads when it is empty or its contents move on.
    assign en_s7 = !s7_v_reg || result.ready;
    assign en_s6 = !s6_v_reg || en_s7;
    assign en_s5 = !s5_v_reg || en_s6;
    assign en_s4 = !s4_v_reg || en_s5;
    assign en_s3 = !s3_v_reg || en_s4;
    assign en_s2 = !s2_v_reg || en_s3;
    assign en_s1 = !s1_v_reg || en_s2;

    assign query.ready  = en_s1;
    assign result.valid = s7_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end
        else
        begin
            if (en_s1) s1_v_reg <= query.valid;
            if (en_s2) s2_v_reg <= s1_v_reg;
            if (en_s3) s3_v_reg <= s2_v_reg;
            if (en_s4) s4_v_reg <= s3_v_reg;
            if (en_s5) s5_v_reg <= s4_v_reg;
            if (en_s6) s6_v_reg <= s5_v_reg;
            if (en_s7) s7_v_reg <= s6_v_reg;
        end
    end

    // ------------------------------------------------- s1: differences
    logic signed [DW-1:0]  s1_abx_reg, s1_aby_reg, s1_apx_reg, s1_apy_reg;
    logic signed [DW-1:0]  s1_bpx_reg, s1_bpy_reg;
    logic signed [DW-1:0]  s1_abx_next, s1_aby_next, s1_apx_next, s1_apy_next;
    logic signed [DW-1:0]  s1_bpx_next, s1_bpy_next;
    logic [RSW-1:0]        s1_rsum_reg, s1_rsum_next;

    always_comb
    begin
        s1_abx_next  = DW'(query.seg_bx)   - DW'(query.seg_ax);
        s1_aby_next  = DW'(query.seg_by)   - DW'(query.seg_ay);
        s1_apx_next  = DW'(query.circle_x) - DW'(query.seg_ax);
        s1_apy_next  = DW'(query.circle_y) - DW'(query.seg_ay);
        s1_bpx_next  = DW'(query.circle_x) - DW'(query.seg_bx);
        s1_bpy_next  = DW'(query.circle_y) - DW'(query.seg_by);
        s1_rsum_next = RSW'(query.circle_radius) + RSW'(query.capsule_radius);
    end

    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            s1_abx_reg  <= s1_abx_next;
            s1_aby_reg  <= s1_aby_next;
            s1_apx_reg  <= s1_apx_next;
            s1_apy_reg  <= s1_apy_next;
            s1_bpx_reg  <= s1_bpx_next;
            s1_bpy_reg  <= s1_bpy_next;
            s1_rsum_reg <= s1_rsum_next;
        end
    end

    // ---------------------------------------------------- s2: products
    // Naming: s2_<u><v>_<axis> is u.axis * v.axis; cross terms are mixed.
    logic signed [PW-1:0] s2_abab_x_reg, s2_abab_y_reg, s2_apab_x_reg, s2_apab_y_reg;
    logic signed [PW-1:0] s2_apap_x_reg, s2_apap_y_reg, s2_bpbp_x_reg, s2_bpbp_y_reg;
    logic signed [PW-1:0] s2_cr_a_reg, s2_cr_b_reg;
    logic signed [PW-1:0] s2_abab_x_next, s2_abab_y_next, s2_apab_x_next, s2_apab_y_next;
    logic signed [PW-1:0] s2_apap_x_next, s2_apap_y_next, s2_bpbp_x_next, s2_bpbp_y_next;
    logic signed [PW-1:0] s2_cr_a_next, s2_cr_b_next;
    logic [R2W-1:0]       s2_r2_reg, s2_r2_next;

    always_comb
    begin
        s2_abab_x_next = s1_abx_reg * s1_abx_reg;
        s2_abab_y_next = s1_aby_reg * s1_aby_reg;
        s2_apab_x_next = s1_apx_reg * s1_abx_reg;
        s2_apab_y_next = s1_apy_reg * s1_aby_reg;
        s2_apap_x_next = s1_apx_reg * s1_apx_reg;
        s2_apap_y_next = s1_apy_reg * s1_apy_reg;
        s2_bpbp_x_next = s1_bpx_reg * s1_bpx_reg;
        s2_bpbp_y_next = s1_bpy_reg * s1_bpy_reg;
        s2_cr_a_next   = s1_apx_reg * s1_aby_reg;
        s2_cr_b_next   = s1_apy_reg * s1_abx_reg;
        s2_r2_next     = s1_rsum_reg * s1_rsum_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_s2)
        begin
            s2_abab_x_reg <= s2_abab_x_next;
            s2_abab_y_reg <= s2_abab_y_next;
            s2_apab_x_reg <= s2_apab_x_next;
            s2_apab_y_reg <= s2_apab_y_next;
            s2_apap_x_reg <= s2_apap_x_next;
            s2_apap_y_reg <= s2_apap_y_next;
            s2_bpbp_x_reg <= s2_bpbp_x_next;
            s2_bpbp_y_reg <= s2_bpbp_y_next;
            s2_cr_a_reg   <= s2_cr_a_next;
            s2_cr_b_reg   <= s2_cr_b_next;
            s2_r2_reg     <= s2_r2_next;
        end
    end

    // ------------------------------------------------- s3: dot / cross
    logic signed [SW-1:0] s3_len2_reg, s3_t_reg, s3_da_reg, s3_db_reg, s3_cr_reg;
    logic signed [SW-1:0] s3_len2_next, s3_t_next, s3_da_next, s3_db_next, s3_cr_next;
    logic [R2W-1:0]       s3_r2_reg;

    always_comb
    begin
        s3_len2_next = SW'(s2_abab_x_reg) + SW'(s2_abab_y_reg);
        s3_t_next    = SW'(s2_apab_x_reg) + SW'(s2_apab_y_reg);
        s3_da_next   = SW'(s2_apap_x_reg) + SW'(s2_apap_y_reg);
        s3_db_next   = SW'(s2_bpbp_x_reg) + SW'(s2_bpbp_y_reg);
        s3_cr_next   = SW'(s2_cr_a_reg)   - SW'(s2_cr_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en_s3)
        begin
            s3_len2_reg <= s3_len2_next;
            s3_t_reg    <= s3_t_next;
            s3_da_reg   <= s3_da_next;
            s3_db_reg   <= s3_db_next;
            s3_cr_reg   <= s3_cr_next;
            s3_r2_reg   <= s2_r2_reg;
        end
    end

    // ------------------------------- s4: region, end-point hit, |cross|
    csct_pkg::region_t    s4_region_reg, s4_region_next;
    logic                 s4_hit_end_reg, s4_hit_end_next;
    logic [MW-1:0]        s4_crmag_reg, s4_crmag_next;
    logic [MW-1:0]        s4_len2_reg;
    logic [R2W-1:0]       s4_r2_reg;
    logic signed [SW-1:0] cr_abs;
    logic                 t_nonpos;

    always_comb
    begin
        t_nonpos = s3_t_reg[SW-1] || (s3_t_reg == '0);
        if ((s3_len2_reg == '0) || t_nonpos)
        begin
            s4_region_next = csct_pkg::REGION_START;
        end
        else if (s3_t_reg >= s3_len2_reg)
        begin
            s4_region_next = csct_pkg::REGION_END;
        end
        else
        begin
            s4_region_next = csct_pkg::REGION_INTERIOR;
        end

        // Squared distances are never negative, so zero extension is exact.
        if (s4_region_next == csct_pkg::REGION_START)
        begin
            s4_hit_end_next = BW'(s3_r2_reg) >= BW'($unsigned(s3_da_reg));
        end
        else
        begin
            s4_hit_end_next = BW'(s3_r2_reg) >= BW'($unsigned(s3_db_reg));
        end

        cr_abs        = s3_cr_reg[SW-1] ? -s3_cr_reg : s3_cr_reg;
        s4_crmag_next = cr_abs[MW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_s4)
        begin
            s4_region_reg  <= s4_region_next;
            s4_hit_end_reg <= s4_hit_end_next;
            s4_crmag_reg   <= s4_crmag_next;
            s4_len2_reg    <= s3_len2_reg[MW-1:0];
            s4_r2_reg      <= s3_r2_reg;
        end
    end

    // --------------------------------------------- s5: split products
    logic [MW-1:0]      s5_hh_reg, s5_hl_reg, s5_ll_reg;
    logic [MW-1:0]      s5_hh_next, s5_hl_next, s5_ll_next;
    logic [R2W+H-1:0]   s5_rh_reg, s5_rl_reg, s5_rh_next, s5_rl_next;
    csct_pkg::region_t  s5_region_reg;
    logic               s5_hit_end_reg;

    always_comb
    begin
        s5_hh_next = s4_crmag_reg[MW-1:H] * s4_crmag_reg[MW-1:H];
        s5_hl_next = s4_crmag_reg[MW-1:H] * s4_crmag_reg[H-1:0];
        s5_ll_next = s4_crmag_reg[H-1:0]  * s4_crmag_reg[H-1:0];
        s5_rh_next = s4_r2_reg * s4_len2_reg[MW-1:H];
        s5_rl_next = s4_r2_reg * s4_len2_reg[H-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_s5)
        begin
            s5_hh_reg      <= s5_hh_next;
            s5_hl_reg      <= s5_hl_next;
            s5_ll_reg      <= s5_ll_next;
            s5_rh_reg      <= s5_rh_next;
            s5_rl_reg      <= s5_rl_next;
            s5_region_reg  <= s4_region_reg;
            s5_hit_end_reg <= s4_hit_end_reg;
        end
    end

    // --------------------------------------------------- s6: wide sums
    logic [CW-1:0]      s6_lhs_reg, s6_rhs_reg, s6_lhs_next, s6_rhs_next;
    csct_pkg::region_t  s6_region_reg;
    logic               s6_hit_end_reg;

    always_comb
    begin
        // (hi*2^H + lo)^2 = hi^2*2^2H + 2*hi*lo*2^H + lo^2
        s6_lhs_next = (CW'(s5_hh_reg) << MW) + (CW'(s5_hl_reg) << (H + 1))
                    + CW'(s5_ll_reg);
        s6_rhs_next = (CW'(s5_rh_reg) << H) + CW'(s5_rl_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en_s6)
        begin
            s6_lhs_reg     <= s6_lhs_next;
            s6_rhs_reg     <= s6_rhs_next;
            s6_region_reg  <= s5_region_reg;
            s6_hit_end_reg <= s5_hit_end_reg;
        end
    end

    // ---------------------------------------- s7: compare, output register
    logic               s7_hit_reg, s7_hit_next;
    csct_pkg::region_t  s7_region_reg;

    always_comb
    begin
        if (s6_region_reg == csct_pkg::REGION_INTERIOR)
        begin
            s7_hit_next = s6_lhs_reg <= s6_rhs_reg;
        end
        else
        begin
            s7_hit_next = s6_hit_end_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s7)
        begin
            s7_hit_reg    <= s7_hit_next;
            s7_region_reg <= s6_region_reg;
        end
    end

    assign result.intersecting   = s7_hit_reg;
    assign result.closest_region = s7_region_reg;

    // ------------------------------------------------------ assertions
`include "circle_segment_capsule_test_assert.svh"

    `CSCT_ASSERT_NEXT(a_accept_fills_s1, query.valid && query.ready, s1_v_reg)
    `CSCT_ASSERT_NEXT(a_s4_holds_on_stall, s4_v_reg && !en_s5, s4_v_reg && $stable(s4_crmag_reg) && $stable(s4_region_reg))
    `CSCT_ASSERT_NEXT(a_degenerate_is_start, s3_v_reg && en_s4 && (s3_len2_reg == '0), s4_region_reg == csct_pkg::REGION_START)
    `CSCT_ASSERT_NEXT(a_on_segment_hits, s6_v_reg && en_s7 && (s6_region_reg == csct_pkg::REGION_INTERIOR) && (s6_lhs_reg == '0), result.intersecting)

endmodule
